### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define AFW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define AFW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/afw_pkg.sv
// ----------------------------------------------------------------------------
// afw_pkg
// types, constants and lookup tables of the amr frame walker
// ----------------------------------------------------------------------------
`default_nettype none

package afw_pkg;

    localparam int MAGIC_LEN      = 6;
    localparam int SEEN_W         = 3;
    localparam int LEN_W          = 5;
    localparam int MS_PER_FRAME   = 20;
    localparam int MS_PER_SEC     = 1000;
    localparam int FRAMES_PER_SEC = MS_PER_SEC / MS_PER_FRAME;
    localparam int SUB_W          = $clog2(FRAMES_PER_SEC);
    localparam int FC_OUT_W       = 16;
    localparam int DUR_W          = 11;
    localparam int OUT_COUNT_MAX  = 65535;

    // one classified byte handed from the front to the back
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             clear_walk;
        logic             is_last;
        logic             hdr;
        logic             long_file;
    } t_item;

    typedef struct packed {
        logic [FC_OUT_W-1:0] frame_count;
        logic [DUR_W-1:0]    duration_seconds;
        logic                header_found;
        logic                walk_stopped;
    } t_result;

    // "#!AMR\n"
    function automatic logic [7:0] magic_byte(input logic [SEEN_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h23;
            3'd1:    b = 8'h21;
            3'd2:    b = 8'h41;
            3'd3:    b = 8'h4D;
            3'd4:    b = 8'h52;
            3'd5:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // data bytes that follow a frame header, by mode
    function automatic logic [LEN_W-1:0] mode_len(input logic [3:0] mode);
        logic [LEN_W-1:0] n;
        unique case (mode)
            4'd0:    n = 5'd12;
            4'd1:    n = 5'd13;
            4'd2:    n = 5'd15;
            4'd3:    n = 5'd17;
            4'd4:    n = 5'd19;
            4'd5:    n = 5'd20;
            4'd6:    n = 5'd26;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd5;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### design/afw_fifo.sv
// ----------------------------------------------------------------------------
// afw_fifo
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module afw_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire afw_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output afw_pkg::t_item      o_item,
    output logic                o_not_empty
);

    afw_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    assign o_full      = r_count == 2'd2;
    assign o_not_empty = r_count != 2'd0;
    assign o_item      = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

### design/afw_front.sv
// ----------------------------------------------------------------------------
// afw_front
// accepts file bytes, checks the magic and looks up the mode length
// ----------------------------------------------------------------------------
`default_nettype none

module afw_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_file_byte,
    input  wire logic       i_is_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output afw_pkg::t_item  o_item
);

    localparam logic [afw_pkg::SEEN_W-1:0] SeenMax = '1;

    logic [afw_pkg::SEEN_W-1:0] r_seen;
    logic                       r_match;
    logic [afw_pkg::SEEN_W-1:0] n_seen;
    logic                       n_match;
    logic                       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        n_match = r_match;
        if (r_seen < afw_pkg::SEEN_W'(afw_pkg::MAGIC_LEN)
            && i_file_byte != afw_pkg::magic_byte(r_seen)) begin
            n_match = 1'b0;
        end
        n_seen = (r_seen == SeenMax) ? SeenMax : r_seen + 1'b1;
    end

    always_comb begin
        o_item.len        = afw_pkg::mode_len(i_file_byte[6:3]);
        // sixth byte completes the magic: the walk restarts after it
        o_item.clear_walk = (r_seen == afw_pkg::SEEN_W'(afw_pkg::MAGIC_LEN - 1)) && n_match;
        o_item.is_last    = i_is_last;
        o_item.hdr        = (n_seen >= afw_pkg::SEEN_W'(afw_pkg::MAGIC_LEN)) && n_match;
        o_item.long_file  = n_seen == SeenMax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_match <= 1'b1;
        end else if (accept) begin
            if (i_is_last) begin
                r_seen  <= '0;
                r_match <= 1'b1;
            end else begin
                r_seen  <= n_seen;
                r_match <= n_match;
            end
        end
    end

endmodule

`default_nettype wire

### design/afw_back.sv
// ----------------------------------------------------------------------------
// afw_back
// walks frames, counts complete ones and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module afw_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire afw_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output afw_pkg::t_result    o_result
);

    localparam logic [COUNT_WIDTH-1:0]     CountMax = '1;
    localparam logic [afw_pkg::DUR_W-1:0]  DurMax   = '1;
    localparam logic [afw_pkg::SUB_W-1:0]  SubLast  =
        afw_pkg::SUB_W'(afw_pkg::FRAMES_PER_SEC - 1);

    logic [afw_pkg::LEN_W-1:0] r_left,   n_left;
    logic                      r_stop,   n_stop;
    logic [COUNT_WIDTH-1:0]    r_frames, n_frames;
    // frames modulo one second, and whole seconds rounded up
    logic [afw_pkg::SUB_W-1:0] r_sub,    n_sub;
    logic [afw_pkg::DUR_W-1:0] r_dur,    n_dur;
    logic                      r_out_valid;
    afw_pkg::t_result          r_result;
    afw_pkg::t_result          n_result;
    logic [31:0]               frames_wide;

    assign o_pop = i_q_valid && (!i_item.is_last || !r_out_valid || i_ready);

    always_comb begin
        n_left   = r_left;
        n_stop   = r_stop;
        n_frames = r_frames;
        n_sub    = r_sub;
        n_dur    = r_dur;
        if (!r_stop) begin
            if (r_left == '0) begin
                if (i_item.len == '0) n_stop = 1'b1;
                else                  n_left = i_item.len;
            end else begin
                n_left = r_left - 1'b1;
                if (n_left == '0 && r_frames != CountMax) begin
                    n_frames = r_frames + 1'b1;
                    if (r_sub == '0 && r_dur != DurMax) n_dur = r_dur + 1'b1;
                    n_sub = (r_sub == SubLast) ? '0 : r_sub + 1'b1;
                end
            end
        end
        if (i_item.clear_walk) begin
            n_left   = '0;
            n_stop   = 1'b0;
            n_frames = '0;
            n_sub    = '0;
            n_dur    = '0;
        end
    end

    always_comb begin
        frames_wide = 32'(n_frames);
        n_result.header_found = i_item.hdr;
        if (i_item.long_file) begin
            n_result.frame_count = (frames_wide > 32'(afw_pkg::OUT_COUNT_MAX))
                ? afw_pkg::FC_OUT_W'(afw_pkg::OUT_COUNT_MAX)
                : frames_wide[afw_pkg::FC_OUT_W-1:0];
            n_result.duration_seconds = n_dur;
            n_result.walk_stopped     = n_stop;
        end else begin
            n_result.frame_count      = '0;
            n_result.duration_seconds = '0;
            n_result.walk_stopped     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_stop      <= 1'b0;
            r_frames    <= '0;
            r_sub       <= '0;
            r_dur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.is_last) begin
                    r_left   <= '0;
                    r_stop   <= 1'b0;
                    r_frames <= '0;
                    r_sub    <= '0;
                    r_dur    <= '0;
                end else begin
                    r_left   <= n_left;
                    r_stop   <= n_stop;
                    r_frames <= n_frames;
                    r_sub    <= n_sub;
                    r_dur    <= n_dur;
                end
            end
            if (o_pop && i_item.is_last) r_out_valid <= 1'b1;
            else if (i_ready)            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.is_last) r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### design/amr_frame_walker_duration.sv
// ----------------------------------------------------------------------------
// amr_frame_walker_duration
// walks an amr-nb storage file byte by byte and reports frames and duration
//
//   channel  dir  handshake           payload
//   byte     in   i_valid / o_ready   i_file_byte, i_is_last
//   result   out  o_valid / i_ready   o_frame_count, o_duration_seconds,
//                                     o_header_found, o_walk_stopped
//
// one byte per cycle while the queue is not full; the front classifies a
// byte in its accept cycle, the back consumes it from a two-entry queue
// the result register loads as the last byte leaves the queue
// o_ready drops only when the queue is full, i.e. a result is held by i_ready
// synchronous active-low reset clears the walk, the queue and the result valid
// ----------------------------------------------------------------------------
`default_nettype none

module amr_frame_walker_duration #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_frame_count,
    output logic [10:0]      o_duration_seconds,
    output logic             o_header_found,
    output logic             o_walk_stopped
);

    afw_pkg::t_item   push_item;
    afw_pkg::t_item   pop_item;
    afw_pkg::t_result result;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;

    afw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_file_byte (i_file_byte),
        .i_is_last   (i_is_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    afw_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_item      (pop_item),
        .o_not_empty (q_not_empty)
    );

    afw_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_frame_count      = result.frame_count;
    assign o_duration_seconds = result.duration_seconds;
    assign o_header_found     = result.header_found;
    assign o_walk_stopped     = result.walk_stopped;

endmodule

`default_nettype wire

### design/afw_checker.sv
// ----------------------------------------------------------------------------
// afw_checker
// port-level checks on the frame walker's results
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module afw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_frame_count,
    input wire logic [10:0] o_duration_seconds,
    input wire logic        o_header_found,
    input wire logic        o_walk_stopped
);

    // a held result keeps its payload
    property p_hold;
        o_valid && !i_ready |=> o_valid && $stable({o_frame_count, o_duration_seconds,
                                                    o_header_found, o_walk_stopped});
    endproperty

    // no frames means no duration
    property p_zero_dur;
        o_valid && o_frame_count == 16'd0 |-> o_duration_seconds == 11'd0;
    endproperty

    // up to one second of frames rounds up to exactly one second
    property p_one_sec;
        o_valid && o_frame_count != 16'd0 && o_frame_count <= 16'd50
            |-> o_duration_seconds == 11'd1;
    endproperty

    `AFW_ASSERT(a_hold, i_clk, i_rst_n, p_hold, "result changed while stalled")

    `AFW_ASSERT(a_zero_dur, i_clk, i_rst_n, p_zero_dur, "duration without frames")

    `AFW_ASSERT(a_one_sec, i_clk, i_rst_n, p_one_sec, "short duration not rounded up")

    // reset clears the result valid
    `AFW_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind amr_frame_walker_duration afw_checker u_afw_checker (.*);

`default_nettype wire
